@@ rtl/bqd_pkg.sv @@
// Shared types and constants for the byte queue with delete by value.
package bqd_pkg;

  localparam int BYTE_W = 8;
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;
  localparam int FILL_W = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_FIND   = 2'd2,
    KIND_NOP    = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RSVD  = 2'd3
  } status_t;

  typedef struct packed {
    logic              find;
    logic [BYTE_W-1:0] key;
  } cell_ctl_t;

endpackage

@@ rtl/byte_queue_with_delete_by_value_unit.sv @@
// Byte queue with delete by value: a row of DEPTH cells, head in cell 0.
// Every operation (append, remove head, find and delete) completes in the cell
// row, so one item is accepted per clock while not stalled. Its result is registered
// and appears the cycle after acceptance. Input stalls only while a result is
// held and the output side stalls. The find search and the gap closing run in
// the same cycle through a one-bit delete chain that runs the length of the
// cell row, from head to tail.
module byte_queue_with_delete_by_value_unit import bqd_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [KIND_W-1:0] kind,
  input  logic [BYTE_W-1:0] value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_value,
  output logic [STAT_W-1:0] status,
  output logic              now_empty,
  output logic [FILL_W-1:0] fill_count
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic              take;
  logic              is_full;
  logic              is_empty;
  logic              op_append;
  logic              op_remove;
  logic              op_find;
  logic              append_ok;
  logic              find_hit;
  cell_ctl_t         ctl;
  logic [DEPTH:0]    del;
  logic [BYTE_W-1:0] data [DEPTH];
  status_t           res_status;
  logic [BYTE_W-1:0] res_value;

  assign in_stall  = out_valid && out_stall;
  assign take      = in_valid && !in_stall;
  assign is_full   = (count == CW'(DEPTH));
  assign is_empty  = (count == '0);
  assign op_append = take && (kind == KIND_APPEND);
  assign op_remove = take && (kind == KIND_REMOVE);
  assign op_find   = take && (kind == KIND_FIND);
  assign append_ok = op_append && !is_full;
  assign find_hit  = op_find && del[DEPTH];

  assign ctl.find = op_find;
  assign ctl.key  = value;
  assign del[0]   = op_remove && !is_empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [BYTE_W-1:0] nd;
    if (i == DEPTH - 1) begin : g_tail
      assign nd = data[i];
    end else begin : g_mid
      assign nd = data[i+1];
    end
    bqd_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (CW'(i) < count),
      .load      (append_ok && (count == CW'(i))),
      .load_data (value),
      .del_in    (del[i]),
      .next_data (nd),
      .data      (data[i]),
      .del_out   (del[i+1])
    );
  end

  always_comb begin
    count_next = count;
    if (append_ok) begin
      count_next = count + CW'(1);
    end else if (del[0] || find_hit) begin
      count_next = count - CW'(1);
    end
  end

  always_comb begin
    res_status = STAT_OK;
    res_value  = '0;
    unique case (kind_t'(kind))
      KIND_APPEND: begin
        if (is_full) begin
          res_status = STAT_FULL;
        end
      end
      KIND_REMOVE: begin
        if (is_empty) begin
          res_status = STAT_EMPTY;
        end else begin
          res_value = data[0];
        end
      end
      KIND_FIND: begin
        if (!del[DEPTH]) begin
          res_status = STAT_EMPTY;
        end
      end
      default: begin
        res_status = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (take) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_value  <= res_value;
      status     <= res_status;
      now_empty  <= (count_next == '0);
      fill_count <= FILL_W'(count_next);
    end
  end

endmodule

@@ rtl/bqd_cell.sv @@
// One queue position: holds a byte, matches the search key, shifts toward the head.
module bqd_cell import bqd_pkg::*; (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic              occupied,
  input  logic              load,
  input  logic [BYTE_W-1:0] load_data,
  input  logic              del_in,
  input  logic [BYTE_W-1:0] next_data,
  output logic [BYTE_W-1:0] data,
  output logic              del_out
);

  logic              match;
  logic [BYTE_W-1:0] data_next;

  assign match   = ctl.find && occupied && (data == ctl.key);
  assign del_out = del_in || match;

  always_comb begin
    priority if (del_out) begin
      data_next = next_data;
    end else if (load) begin
      data_next = load_data;
    end else begin
      data_next = data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

@@ rtl/bqd_checker.sv @@
// Port-level checks for the byte queue with delete by value.
module bqd_checker import bqd_pkg::*; #(
  parameter int DEPTH = 16
) (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [BYTE_W-1:0] out_value,
  input logic [STAT_W-1:0] status,
  input logic              now_empty,
  input logic [FILL_W-1:0] fill_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(status)
      && $stable(fill_count) && $stable(now_empty))
    else $error("stalled result transaction changed");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted transaction produced no result");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_FULL) |-> (fill_count == FILL_W'(DEPTH)) && !now_empty)
    else $error("full status with wrong fill count");

  a_value_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_value != '0) |-> (status == STAT_OK))
    else $error("nonzero value with failing status");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status != STAT_RSVD))
    else $error("reserved status code");

endmodule

bind byte_queue_with_delete_by_value_unit bqd_checker #(.DEPTH(DEPTH)) u_bqd_checker (.*);

@@ tb/testbench.sv @@
// Self-checking testbench for the byte queue with delete by value.
`timescale 1ns / 100ps

module testbench import bqd_pkg::*;;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1400;

  typedef struct packed {
    logic [BYTE_W-1:0] out_value;
    status_t           status;
    logic              now_empty;
    logic [FILL_W-1:0] fill_count;
  } qresult_t;

  typedef struct {
    kind_t             kind;
    logic [BYTE_W-1:0] value;
    bit                fixed;
    qresult_t          result;
  } step_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [KIND_W-1:0] in_kind = '0;
  logic [BYTE_W-1:0] in_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] out_value;
  logic [STAT_W-1:0] status;
  logic              now_empty;
  logic [FILL_W-1:0] fill_count;

  logic [BYTE_W-1:0] shadow_bytes[$];
  qresult_t          pending_results[$];
  step_row_t         script[$];
  int                mismatches = 0;
  int                idle_cycles = 0;
  int                burst_left = 0;
  int                stall_mode = 0;
  int                stall_left = 0;
  int                stall_phase = 0;

  byte_queue_with_delete_by_value_unit #(.DEPTH(QUEUE_DEPTH)) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (in_kind),
    .value      (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .status     (status),
    .now_empty  (now_empty),
    .fill_count (fill_count)
  );

  always #1 clk = ~clk;

  function automatic qresult_t apply_queue_op(kind_t k, logic [BYTE_W-1:0] v);
    qresult_t r;
    int hit;
    r = '0;
    r.status = STAT_OK;
    hit = -1;
    case (k)
      KIND_APPEND: begin
        if (shadow_bytes.size() >= QUEUE_DEPTH) r.status = STAT_FULL;
        else shadow_bytes.push_back(v);
      end
      KIND_REMOVE: begin
        if (shadow_bytes.size() == 0) r.status = STAT_EMPTY;
        else r.out_value = shadow_bytes.pop_front();
      end
      KIND_FIND: begin
        for (int i = 0; i < shadow_bytes.size() && hit < 0; i++)
          if (shadow_bytes[i] == v) hit = i;
        if (hit >= 0) shadow_bytes.delete(hit);
        else r.status = STAT_EMPTY;
      end
      default: ;
    endcase
    r.now_empty = (shadow_bytes.size() == 0);
    r.fill_count = FILL_W'(shadow_bytes.size());
    return r;
  endfunction

  task automatic add_row(kind_t k, logic [BYTE_W-1:0] v, bit fixed, qresult_t r);
    step_row_t row;
    row.kind = k;
    row.value = v;
    row.fixed = fixed;
    row.result = r;
    script.push_back(row);
  endtask

  task automatic send_item(kind_t k, logic [BYTE_W-1:0] v, bit fixed, qresult_t fixed_res);
    qresult_t r;
    in_valid <= 1'b1;
    in_kind <= k;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = apply_queue_op(k, v);
    if (fixed) r = fixed_res;
    pending_results.push_back(r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
  endtask

  // receiver stall pattern: none, light, heavy, periodic
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(50, 400);
      end else begin
        stall_left--;
      end
      stall_phase++;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (stall_phase % 8 < 5);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    qresult_t seen;
    qresult_t want;
    if (!rst && out_valid && !out_stall) begin
      seen = '{out_value, status_t'(status), now_empty, fill_count};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: out_value %h status %0d empty %b fill %0d",
                   seen.out_value, seen.status, seen.now_empty, seen.fill_count);
      end else begin
        want = pending_results.pop_front();
        if (seen.out_value !== want.out_value || seen.status !== want.status ||
            seen.now_empty !== want.now_empty || seen.fill_count !== want.fill_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: out_value %h/%h status %0d/%0d empty %b/%b ",
                      "fill %0d/%0d (expected/actual)"},
                     want.out_value, seen.out_value, want.status, seen.status,
                     want.now_empty, seen.now_empty, want.fill_count, seen.fill_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL byte_queue_with_delete_by_value_unit");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int mode;
    int mode_left;
    int pick;
    kind_t k;
    logic [BYTE_W-1:0] v;

    add_row(KIND_REMOVE, 8'h00, 1, '{8'h00, STAT_EMPTY, 1'b1, 5'd0});
    add_row(KIND_FIND,   8'h00, 1, '{8'h00, STAT_EMPTY, 1'b1, 5'd0});
    add_row(KIND_NOP,    8'hFF, 1, '{8'h00, STAT_OK,    1'b1, 5'd0});
    add_row(KIND_APPEND, 8'h00, 1, '{8'h00, STAT_OK,    1'b0, 5'd1});
    add_row(KIND_APPEND, 8'hFF, 1, '{8'h00, STAT_OK,    1'b0, 5'd2});
    for (int i = 0; i < QUEUE_DEPTH - 2; i++)
      add_row(KIND_APPEND, (i % 3 == 0) ? 8'hFF : 8'(8'h11 * i), 0, '0);
    add_row(KIND_APPEND, 8'h80, 1, '{8'h00, STAT_FULL,  1'b0, 5'd16});
    add_row(KIND_NOP,    8'h00, 1, '{8'h00, STAT_OK,    1'b0, 5'd16});
    add_row(KIND_FIND,   8'hFF, 0, '0);
    add_row(KIND_FIND,   8'hDD, 0, '0);
    add_row(KIND_FIND,   8'h5A, 1, '{8'h00, STAT_EMPTY, 1'b0, 5'd14});
    add_row(KIND_REMOVE, 8'h00, 1, '{8'h00, STAT_OK,    1'b0, 5'd13});
    add_row(KIND_FIND,   8'hFF, 0, '0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i])
      send_item(script[i].kind, script[i].value, script[i].fixed, script[i].result);

    // fill-heavy, drain-heavy and mixed phases move the queue between full and empty
    mode = 0;
    mode_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      pick = $urandom_range(0, 99);
      if (pick < 4) k = KIND_NOP;
      else if (mode == 0) k = (pick < 70) ? KIND_APPEND : (pick < 85) ? KIND_REMOVE : KIND_FIND;
      else if (mode == 1) k = (pick < 20) ? KIND_APPEND : (pick < 60) ? KIND_REMOVE : KIND_FIND;
      else k = (pick < 45) ? KIND_APPEND : (pick < 70) ? KIND_REMOVE : KIND_FIND;
      if ($urandom_range(0, 2) == 0) v = 8'($urandom_range(0, 255));
      else v = 8'($urandom_range(0, 7));
      send_item(k, v, 0, '0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS byte_queue_with_delete_by_value_unit");
    end else begin
      $display("FAIL byte_queue_with_delete_by_value_unit");
    end
    $finish;
  end

endmodule
